// ===== rtl/nsc_pkg.sv =====
// Shared types, constants and helpers for the NMEA sentence checker.
// Used by nsc_line_tracker, nmea_sentence_checker and nsc_checker.
// No dependencies.
package nsc_pkg;

  // Line length limit and field count limit
  localparam int unsigned LINE_LENGTH = 80;
  localparam int unsigned FIELD_LIMIT = 16;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned COUNT_W = 5;

  // Characters of interest
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  // Sentence type texts, one character per entry
  localparam logic [7:0] RMC_TEXT [3] = '{8'h52, 8'h4D, 8'h43};
  localparam logic [7:0] GGA_TEXT [3] = '{8'h47, 8'h47, 8'h41};

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_RMC   = 2'd1,
    KIND_GGA   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_MATCH = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_BAD   = 2'd2
  } status_t;

  // One result item, last field (sentence_kind) in the lowest bits
  typedef struct packed {
    logic               truncated;
    logic [7:0]         computed_sum;
    logic [COUNT_W-1:0] field_count;
    status_t            check_status;
    kind_t              sentence_kind;
  } result_t;

  localparam int unsigned RESULT_W    = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, 4'(c - 8'h57)};
    end
    return res;
  endfunction

endpackage

// ===== rtl/nsc_line_tracker.sv =====
// Per-line state of the NMEA sentence checker: position, XOR, checksum
// digits, comma count and type match. Builds the result at the line end.
// Depends on nsc_pkg.
module nsc_line_tracker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  input  logic [7:0]      byte_data,
  output logic            result_valid,
  output nsc_pkg::result_t result
);

  logic [nsc_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        is_sentence_r, is_sentence_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic                        in_check_r, in_check_nxt;
  logic [7:0]                  rx_sum_r, rx_sum_nxt;
  logic [1:0]                  hex_cnt_r, hex_cnt_nxt;
  logic                        hex_err_r, hex_err_nxt;
  logic [nsc_pkg::COUNT_W-1:0] comma_r, comma_nxt;
  logic [5:0]                  type_bits_r, type_bits_nxt;
  logic                        ovf_r, ovf_nxt;

  logic       is_eol;
  logic [4:0] hex;
  logic [1:0] k;
  logic [2:0] k_gga;

  assign is_eol = (byte_data == nsc_pkg::CHAR_CR) || (byte_data == nsc_pkg::CHAR_LF);
  assign hex    = nsc_pkg::hex_decode(byte_data);
  assign k      = 2'(pos_r - nsc_pkg::POS_W'(3));
  assign k_gga  = {1'b0, k} + 3'd3;

  // Advance the line state for one transferred byte
  always_comb begin
    pos_nxt         = pos_r;
    is_sentence_nxt = is_sentence_r;
    xor_nxt         = xor_r;
    in_check_nxt    = in_check_r;
    rx_sum_nxt      = rx_sum_r;
    hex_cnt_nxt     = hex_cnt_r;
    hex_err_nxt     = hex_err_r;
    comma_nxt       = comma_r;
    type_bits_nxt   = type_bits_r;
    ovf_nxt         = ovf_r;
    if (byte_valid) begin
      if (is_eol) begin
        if (pos_r != '0) begin
          pos_nxt         = '0;
          is_sentence_nxt = 1'b0;
          xor_nxt         = '0;
          in_check_nxt    = 1'b0;
          rx_sum_nxt      = '0;
          hex_cnt_nxt     = '0;
          hex_err_nxt     = 1'b0;
          comma_nxt       = '0;
          type_bits_nxt   = '1;
          ovf_nxt         = 1'b0;
        end
      end else if (byte_data == nsc_pkg::CHAR_NUL) begin
        // drop NUL bytes entirely
      end else if (pos_r >= nsc_pkg::POS_W'(nsc_pkg::LINE_LENGTH)) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + nsc_pkg::POS_W'(1);
        if (pos_r == '0) begin
          is_sentence_nxt = (byte_data == nsc_pkg::CHAR_DOLLAR);
        end else begin
          // Match type characters three to five
          if (pos_r >= nsc_pkg::POS_W'(3) && pos_r <= nsc_pkg::POS_W'(5)) begin
            if (in_check_r || byte_data == nsc_pkg::CHAR_STAR) begin
              type_bits_nxt = '0;
            end else begin
              if (byte_data != nsc_pkg::RMC_TEXT[k]) type_bits_nxt[{1'b0, k}] = 1'b0;
              if (byte_data != nsc_pkg::GGA_TEXT[k]) type_bits_nxt[k_gga] = 1'b0;
            end
          end
          if (in_check_r) begin
            // Collect checksum digits
            if (!hex[4] || hex_cnt_r >= 2'd2) begin
              hex_err_nxt = 1'b1;
              if (hex_cnt_r != 2'd3) hex_cnt_nxt = hex_cnt_r + 2'd1;
            end else begin
              rx_sum_nxt  = {rx_sum_r[3:0], hex[3:0]};
              hex_cnt_nxt = hex_cnt_r + 2'd1;
            end
          end else if (byte_data == nsc_pkg::CHAR_STAR) begin
            in_check_nxt = 1'b1;
          end else begin
            xor_nxt = xor_r ^ byte_data;
            if (byte_data == nsc_pkg::CHAR_COMMA &&
                comma_r < nsc_pkg::COUNT_W'(nsc_pkg::FIELD_LIMIT - 1)) begin
              comma_nxt = comma_r + nsc_pkg::COUNT_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      is_sentence_r <= 1'b0;
      xor_r         <= '0;
      in_check_r    <= 1'b0;
      rx_sum_r      <= '0;
      hex_cnt_r     <= '0;
      hex_err_r     <= 1'b0;
      comma_r       <= '0;
      type_bits_r   <= '1;
      ovf_r         <= 1'b0;
    end else begin
      pos_r         <= pos_nxt;
      is_sentence_r <= is_sentence_nxt;
      xor_r         <= xor_nxt;
      in_check_r    <= in_check_nxt;
      rx_sum_r      <= rx_sum_nxt;
      hex_cnt_r     <= hex_cnt_nxt;
      hex_err_r     <= hex_err_nxt;
      comma_r       <= comma_nxt;
      type_bits_r   <= type_bits_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

  // Emit a result when a sentence line ends
  assign result_valid = byte_valid && is_eol && (pos_r != '0) && is_sentence_r;

  always_comb begin
    result.sentence_kind = nsc_pkg::KIND_OTHER;
    if (pos_r >= nsc_pkg::POS_W'(6) && type_bits_r[2:0] == 3'b111) begin
      result.sentence_kind = nsc_pkg::KIND_RMC;
    end else if (pos_r >= nsc_pkg::POS_W'(6) && type_bits_r[5:3] == 3'b111) begin
      result.sentence_kind = nsc_pkg::KIND_GGA;
    end
    if (!in_check_r) begin
      result.check_status = nsc_pkg::STATUS_NONE;
    end else if (hex_err_r || hex_cnt_r == 2'd0 || rx_sum_r != xor_r) begin
      result.check_status = nsc_pkg::STATUS_BAD;
    end else begin
      result.check_status = nsc_pkg::STATUS_MATCH;
    end
    result.field_count  = comma_r + nsc_pkg::COUNT_W'(1);
    result.computed_sum = xor_r;
    result.truncated    = ovf_r;
  end

endmodule

// ===== rtl/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker: line tracker plus output stage
// with a skid register. Depends on nsc_pkg and nsc_line_tracker.
//
// Usage:
//   The input channel (in_*) carries one received ASCII byte per transfer.
//   A line ends at CR or LF; a line that began with '$' yields one result
//   on the output channel (out_*): sentence type, checksum status, field
//   count, computed XOR and a truncation flag. Other lines yield nothing.
//   Throughput: one byte per cycle while in_tready is high. All per-byte
//   work is a single pass of logic into the line state registers.
//   Result path: the transfer of the CR or LF that ends a line loads its
//   result into the output register, or into the skid register if held.
//   Stall: the output register holds a waiting result, and one more result
//   can park in the skid register; in_tready drops only while the skid
//   register is full, so bytes keep flowing while the receiver takes
//   one result late.
//   Reset: rst_n (synchronous, active low) drops any partial line and any
//   pending result; the block takes bytes in the first cycle after reset.
module nmea_sentence_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] sentence_kind, [3:2] check_status, [8:4] field_count,
  // [16:9] computed_sum, [17] truncated, rest zero
  output logic [nsc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic              byte_valid;
  logic              res_valid;
  nsc_pkg::result_t  res;

  logic              out_valid_r, out_valid_nxt;
  nsc_pkg::result_t  out_data_r, out_data_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  nsc_pkg::result_t  skid_data_r, skid_data_nxt;

  assign in_tready  = !skid_valid_r;
  assign byte_valid = in_tvalid && in_tready;

  nsc_line_tracker u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_data    (in_tdata),
    .result_valid (res_valid),
    .result       (res)
  );

  // Load the output register from skid or tracker; park a result when stalled
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = nsc_pkg::OUT_TDATA_W'(out_data_r);

endmodule

// ===== rtl/nsc_checker.sv =====
// Port-level assertions for the NMEA sentence checker, bound to the top.
// Depends on nsc_pkg and nmea_sentence_checker.
module nsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [7:0]                      in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [nsc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // A fresh result follows only a transfer of a line end
  a_out_after_eol: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready &&
      (in_tdata == nsc_pkg::CHAR_CR || in_tdata == nsc_pkg::CHAR_LF)))
    else $error("result without a line end");

  // Field codes stay within their ranges
  a_codes_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3 && out_tdata[3:2] != 2'd3 &&
      out_tdata[8:4] != 5'd0 && out_tdata[8:4] <= 5'(nsc_pkg::FIELD_LIMIT))
    else $error("illegal result code");

  // Input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !$past(out_tready))
    else $error("input stalled without a waiting result");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
